### rtl/core/hfct_pkg.sv
// Shared types, constants and the key hash function of the flow context table.
package hfct_pkg;

    localparam int NumBuckets = 64;
    localparam int Ways       = 4;
    localparam int TableSize  = NumBuckets * Ways;
    localparam int BucketW    = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
    localparam int WayW       = (Ways > 1) ? $clog2(Ways) : 1;
    localparam int IndexW     = (TableSize > 1) ? $clog2(TableSize) : 1;
    localparam int WayCntW    = $clog2(Ways + 1);
    localparam int KeyW       = 48;

    localparam logic [31:0] Golden = 32'h9e3779b9;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_REMOVED   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic hash_step;
        logic scan_clear;
        logic scan_step;
        logic commit;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        logic hash_done;
        logic scan_done;
    } t_stat;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_abc;

    // One third of the mix: three dependent subtract/xor rows.
    function automatic t_abc mix_third(t_abc v, logic [1:0] step);
        t_abc r;
        r = v;
        unique case (step)
            2'd0: begin
                r.a = r.a - r.b - r.c; r.a = r.a ^ (r.c >> 13);
                r.b = r.b - r.c - r.a; r.b = r.b ^ (r.a << 8);
                r.c = r.c - r.a - r.b; r.c = r.c ^ (r.b >> 13);
            end
            2'd1: begin
                r.a = r.a - r.b - r.c; r.a = r.a ^ (r.c >> 12);
                r.b = r.b - r.c - r.a; r.b = r.b ^ (r.a << 16);
                r.c = r.c - r.a - r.b; r.c = r.c ^ (r.b >> 5);
            end
            default: begin
                r.a = r.a - r.b - r.c; r.a = r.a ^ (r.c >> 3);
                r.b = r.b - r.c - r.a; r.b = r.b ^ (r.a << 10);
                r.c = r.c - r.a - r.b; r.c = r.c ^ (r.b >> 15);
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/core/hashed_flow_context_table_core.sv
// Top level of the hashed flow context table.
// One item at a time: the hash applies one third of the mix per step, the way
// scan reads the ways in turn through the single read port of the key memory,
// then come the write-back state and the output state before o_valid. The
// result is shown for one cycle on o_valid and must be taken then, since the
// receiver cannot stall. No clearing pass after reset.
module hashed_flow_context_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_key_addr,
    input  logic [15:0] i_key_port,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [7:0]  o_entry_index,
    output logic [5:0]  o_bucket_index
);
    import hfct_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    hfct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    hfct_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .o_stat         (w_stat),
        .i_cmd          (i_cmd),
        .i_key_addr     (i_key_addr),
        .i_key_port     (i_key_port),
        .o_strobe       (o_valid),
        .o_status       (o_status),
        .o_entry_index  (o_entry_index),
        .o_bucket_index (o_bucket_index)
    );

endmodule

### rtl/core/hfct_ctrl.sv
// Controller state machine of the flow context table.
module hfct_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  hfct_pkg::t_stat i_stat,
    output hfct_pkg::t_ctrl o_ctrl
);
    import hfct_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_HASH;
            S_HASH:  if (i_stat.hash_done) n_state = S_SCAN;
            S_SCAN:  if (i_stat.scan_done) n_state = S_WRITE;
            S_WRITE: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        busy   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy        = 1'b0;
                o_ctrl.load = start;
            end
            S_HASH: begin
                o_ctrl.hash_step  = 1'b1;
                o_ctrl.scan_clear = i_stat.hash_done;
            end
            S_SCAN:  o_ctrl.scan_step = 1'b1;
            S_WRITE: o_ctrl.commit = 1'b1;
            S_DONE:  o_ctrl.emit = 1'b1;
            default: busy = 1'b1;
        endcase
    end

endmodule

### rtl/core/hfct_dp.sv
// Datapath of the flow context table: hash unit, table memory, way scan.
module hfct_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hfct_pkg::t_ctrl i_ctrl,
    output hfct_pkg::t_stat o_stat,
    input  logic [1:0]      i_cmd,
    input  logic [31:0]     i_key_addr,
    input  logic [15:0]     i_key_port,
    output logic            o_strobe,
    output logic [2:0]      o_status,
    output logic [7:0]      o_entry_index,
    output logic [5:0]      o_bucket_index
);
    import hfct_pkg::*;

    logic [KeyW-1:0]    r_key_mem [TableSize];
    logic [TableSize-1:0] r_valid;

    t_cmd               r_cmd;
    logic [KeyW-1:0]    r_key;
    t_abc               r_abc;
    logic [1:0]         r_hstep;
    logic [BucketW-1:0] r_bucket;
    logic [WayCntW-1:0] r_way;
    logic [KeyW-1:0]    r_rd_key;
    logic               r_rd_pend;
    logic               r_hit;
    logic               r_free_ok;
    logic [WayW-1:0]    r_hit_way;
    logic [WayW-1:0]    r_free_way;
    logic [WayW-1:0]    r_rd_way;
    t_status            w_status;
    logic [IndexW-1:0]  w_index;
    logic               r_strobe;

    t_abc               w_init;
    logic [IndexW-1:0]  w_rd_addr;
    logic [IndexW-1:0]  w_pend_addr;
    logic [IndexW-1:0]  w_base;

    always_comb begin
        w_init.a = Golden + {i_key_addr[23:16], 24'd0} + {8'd0, i_key_addr[15:8], 16'd0}
                 + {16'd0, i_key_addr[7:0], 8'd0};
        w_init.b = Golden + {8'd0, i_key_port[15:8], 16'd0} + {16'd0, i_key_port[7:0], 8'd0}
                 + {24'd0, i_key_addr[31:24]};
        w_init.c = '0;
    end

    assign w_base      = IndexW'(r_bucket) * IndexW'(Ways);
    assign w_rd_addr   = w_base + IndexW'(r_way[WayW-1:0]);
    assign w_pend_addr = w_base + IndexW'(r_rd_way);

    assign o_stat.hash_done = (r_hstep == 2'd2);
    assign o_stat.scan_done = r_rd_pend && (r_way == WayCntW'(Ways));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan_step && r_way != WayCntW'(Ways)) begin
            r_rd_key <= r_key_mem[w_rd_addr];
        end
        if (i_ctrl.commit && w_status == ST_INSERTED) begin
            r_key_mem[w_index] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_strobe  <= 1'b0;
            r_rd_pend <= 1'b0;
            r_hstep   <= '0;
        end else begin
            r_strobe <= i_ctrl.emit;
            if (i_ctrl.load) begin
                r_cmd   <= t_cmd'(i_cmd);
                r_key   <= {i_key_addr, i_key_port};
                r_abc   <= w_init;
                r_hstep <= '0;
            end
            if (i_ctrl.hash_step) begin
                r_abc   <= mix_third(r_abc, r_hstep);
                r_hstep <= r_hstep + 2'd1;
                if (r_hstep == 2'd2) begin
                    r_bucket <= BucketW'(mix_third(r_abc, r_hstep).c % NumBuckets);
                end
            end
            if (i_ctrl.scan_clear) begin
                r_way     <= '0;
                r_rd_pend <= 1'b0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
            end
            if (i_ctrl.scan_step) begin
                if (r_way != WayCntW'(Ways)) begin
                    r_way    <= r_way + 1'b1;
                    r_rd_way <= r_way[WayW-1:0];
                end
                r_rd_pend <= (r_way != WayCntW'(Ways));
                if (r_rd_pend) begin
                    if (r_valid[w_pend_addr]) begin
                        if (!r_hit && r_rd_key == r_key) begin
                            r_hit     <= 1'b1;
                            r_hit_way <= r_rd_way;
                        end
                    end else if (!r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_way <= r_rd_way;
                    end
                end
            end
            if (i_ctrl.commit) begin
                if (w_status == ST_INSERTED) begin
                    r_valid[w_index] <= 1'b1;
                end else if (w_status == ST_REMOVED) begin
                    r_valid[w_index] <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        w_status = ST_NOT_FOUND;
        w_index  = '0;
        if (r_hit) begin
            w_index  = w_base + IndexW'(r_hit_way);
            w_status = (r_cmd == CMD_REMOVE) ? ST_REMOVED : ST_FOUND;
        end else if (r_cmd == CMD_INSERT) begin
            if (r_free_ok) begin
                w_index  = w_base + IndexW'(r_free_way);
                w_status = ST_INSERTED;
            end else begin
                w_status = ST_FULL;
            end
        end
    end

    logic [2:0] r_out_status;
    logic [7:0] r_out_index;
    logic [5:0] r_out_bucket;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_out_status <= w_status;
            r_out_index  <= 8'(w_index);
            r_out_bucket <= 6'(r_bucket);
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_out_status;
    assign o_entry_index  = r_out_index;
    assign o_bucket_index = r_out_bucket;

endmodule

### test/hashed_flow_context_table_core_tb.sv
// Testbench for the hashed flow context table: directed and random commands checked against a table model.
`timescale 1ns / 100ps

module hashed_flow_context_table_core_tb;
    import hfct_pkg::*;

    localparam int CycleLimit = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [31:0] i_key_addr;
    logic [15:0] i_key_port;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [7:0]  o_entry_index;
    logic [5:0]  o_bucket_index;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] entry_index;
        logic [5:0] bucket_index;
    } t_outcome;

    logic        mdl_valid [TableSize];
    logic [47:0] mdl_key [TableSize];
    t_outcome    outcome_q[$];
    int          errors;
    int          cycles;
    int          idle_pct;
    logic [31:0] pool_addr [16];
    logic [15:0] pool_port [16];

    hashed_flow_context_table_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_key_addr     (i_key_addr),
        .i_key_port     (i_key_port),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_entry_index  (o_entry_index),
        .o_bucket_index (o_bucket_index)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] flow_hash(logic [31:0] addr, logic [15:0] port);
        logic [31:0] a, b, c;
        a = 32'h9e3779b9;
        b = 32'h9e3779b9;
        c = 32'd0;
        b += {8'd0, port[15:8], 16'd0};
        b += {16'd0, port[7:0], 8'd0};
        b += {24'd0, addr[31:24]};
        a += {addr[23:16], 24'd0};
        a += {8'd0, addr[15:8], 16'd0};
        a += {16'd0, addr[7:0], 8'd0};
        a = a - b - c; a = a ^ (c >> 13);
        b = b - c - a; b = b ^ (a << 8);
        c = c - a - b; c = c ^ (b >> 13);
        a = a - b - c; a = a ^ (c >> 12);
        b = b - c - a; b = b ^ (a << 16);
        c = c - a - b; c = c ^ (b >> 5);
        a = a - b - c; a = a ^ (c >> 3);
        b = b - c - a; b = b ^ (a << 10);
        c = c - a - b; c = c ^ (b >> 15);
        return c;
    endfunction

    function automatic t_outcome table_update(t_cmd cmd, logic [31:0] addr, logic [15:0] port);
        t_outcome r;
        int bucket, base, hit, free_way, idx;
        bucket   = flow_hash(addr, port) % NumBuckets;
        base     = bucket * Ways;
        hit      = -1;
        free_way = -1;
        idx      = 0;
        r.status = ST_NOT_FOUND;
        for (int w = 0; w < Ways; w++) begin
            if (mdl_valid[base + w]) begin
                if (hit < 0 && mdl_key[base + w] == {addr, port}) hit = w;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        if (hit >= 0) begin
            idx = base + hit;
            if (cmd == CMD_REMOVE) begin
                mdl_valid[idx] = 1'b0;
                r.status = ST_REMOVED;
            end else begin
                r.status = ST_FOUND;
            end
        end else if (cmd == CMD_INSERT) begin
            if (free_way >= 0) begin
                idx = base + free_way;
                mdl_valid[idx] = 1'b1;
                mdl_key[idx] = {addr, port};
                r.status = ST_INSERTED;
            end else begin
                r.status = ST_FULL;
            end
        end
        r.entry_index  = idx[7:0];
        r.bucket_index = bucket[5:0];
        return r;
    endfunction

    // hold start between transfers unless idling
    task automatic send_command(t_cmd cmd, logic [31:0] addr, logic [15:0] port);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_key_addr <= addr;
        i_key_port <= port;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        outcome_q.push_back(table_update(cmd, addr, port));
    endtask

    always @(posedge i_clk) begin
        t_outcome exp;
        if (i_rst_n && o_valid) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected result status=%0d", o_status);
                errors++;
            end else begin
                exp = outcome_q.pop_front();
                if (o_status !== exp.status) begin
                    $error("status exp %0d got %0d", exp.status, o_status);
                    errors++;
                end
                if (o_entry_index !== exp.entry_index) begin
                    $error("entry_index exp %0d got %0d", exp.entry_index, o_entry_index);
                    errors++;
                end
                if (o_bucket_index !== exp.bucket_index) begin
                    $error("bucket_index exp %0d got %0d", exp.bucket_index, o_bucket_index);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_command(CMD_LOOKUP, 32'h0, 16'h0);
        send_command(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        send_command(CMD_INSERT, 32'h0, 16'h0);
        send_command(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_command(CMD_LOOKUP, 32'h0, 16'h0);
        send_command(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        send_command(CMD_INSERT, 32'h0, 16'h0);
        send_command(CMD_REMOVE, 32'h0, 16'h0);
        send_command(CMD_LOOKUP, 32'h0, 16'h0);
        send_command(CMD_UNUSED, 32'h1234_5678, 16'h9ABC);
        send_command(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // fill one bucket beyond its ways to reach the full case
    task automatic test_bucket_full();
        logic [31:0] addr;
        logic [15:0] port;
        int target, n;
        target = flow_hash(32'hA5A5_0000, 16'h0) % NumBuckets;
        n = 0;
        while (n < Ways + 2) begin
            addr = $urandom;
            port = $urandom;
            if (flow_hash(addr, port) % NumBuckets == target) begin
                send_command(CMD_INSERT, addr, port);
                n++;
            end
        end
    endtask

    task automatic test_random(int count);
        logic [31:0] addr;
        logic [15:0] port;
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(15);
            if ($urandom_range(3) == 0) begin
                addr = $urandom;
                port = $urandom;
            end else begin
                addr = pool_addr[sel];
                port = pool_port[sel];
            end
            send_command(t_cmd'($urandom_range(3)), addr, port);
        end
    endtask

    initial begin
        errors     = 0;
        cycles     = 0;
        idle_pct   = 33;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = CMD_LOOKUP;
        i_key_addr = '0;
        i_key_port = '0;
        for (int i = 0; i < TableSize; i++) mdl_valid[i] = 1'b0;
        for (int i = 0; i < 16; i++) begin
            pool_addr[i] = $urandom;
            pool_port[i] = $urandom;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_bucket_full();
        test_random(530);
        idle_pct = 82;
        test_random(530);
        idle_pct = 0;
        test_random(530);
        start <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
